// ----- sv/vrc_pkg.sv -----
package vrc_pkg;

    // grid and counter sizing
    localparam int GRID_X      = 64;
    localparam int GRID_Y      = 64;
    localparam int GRID_Z      = 16;
    localparam int MAX_STEPS   = 256;
    localparam int COUNT_WIDTH = 16;

    localparam int NVOX    = GRID_X * GRID_Y * GRID_Z;
    localparam int VOX_W   = $clog2(NVOX);
    localparam int EDGE_W  = 25;
    localparam int CRD_W   = 36;
    localparam int NUM_W   = 50;
    localparam int DEN_W   = 41;
    localparam int Q_W     = NUM_W + 1;
    localparam int MAG_W   = 18;
    localparam int DIST_W  = EDGE_W + $clog2(MAX_STEPS + 2);
    localparam int PROD_W  = DIST_W + MAG_W;
    localparam int STEP_W  = $clog2(MAX_STEPS + 1);
    localparam int CNTX_W  = (STEP_W > 9) ? STEP_W : 9;
    localparam int SUM_W   = COUNT_WIDTH + 2;
    localparam int RATIO_W = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [17:0] NO_SCORE = -18'sd65536;

    typedef enum logic [2:0] {
        JOB_CX, JOB_CY, JOB_CZ, JOB_TX, JOB_TY, JOB_TZ, JOB_RATIO
    } t_job;

    typedef enum logic [1:0] {
        PAIR_XY, PAIR_XZ, PAIR_YZ
    } t_pair;

    typedef enum logic [1:0] {
        OK_CARVE, OK_NOSCORE, OK_ZERO, OK_RATIO
    } t_okind;

    typedef enum logic [1:0] {
        LBL_NONE, LBL_STATIC, LBL_DYNAMIC
    } t_label;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GX, CFG_GY, CFG_GZ, CFG_EDGE, CFG_THR
    } t_cfg_idx;

    typedef struct packed {
        logic             clr_we;
        logic [VOX_W-1:0] clr_addr;
        logic             latch_in;
        logic             prep;
        logic             div_start;
        logic             div_store;
        t_job             job;
        logic             init_march;
        logic             mul;
        logic             cmp;
        t_pair            pair;
        logic             advance;
        logic             rd;
        logic             use_t;
        logic             wr;
        logic             count_inc;
        logic             out_load;
        t_okind           okind;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic func;
        logic hit;
        logic same;
        logic c_in;
        logic t_in;
        logic total_zero;
        logic step_last;
    } t_sts;

endpackage

// ----- sv/vrc_ram.sv -----
module vrc_ram #(
    parameter int W = 16,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/vrc_div.sv -----
module vrc_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [vrc_pkg::NUM_W-1:0]  i_num,
    input  logic [vrc_pkg::DEN_W-1:0]         i_den,
    output logic                              o_done,
    output logic signed [vrc_pkg::Q_W-1:0]    o_q,
    output logic [vrc_pkg::DEN_W-1:0]         o_rem
);
    import vrc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_acc;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;

    logic [DEN_W:0]   shifted;
    logic             ge;
    logic [DEN_W:0]   diff;
    logic [NUM_W-1:0] num_abs;
    logic [Q_W-1:0]   q_mag;
    logic             rem_nz;

    // one quotient bit per cycle, restoring
    assign shifted = {r_acc, r_quo[NUM_W-1]};
    assign ge      = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};
    assign num_abs = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_W'(NUM_W);
            r_acc <= '0;
            r_quo <= num_abs;
            r_den <= i_den;
            r_neg <= i_num[NUM_W-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_acc <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

    // floor correction for a negative dividend
    assign q_mag  = {1'b0, r_quo};
    assign rem_nz = r_acc != '0;
    assign o_q    = !r_neg ? $signed(q_mag) : (rem_nz ? $signed(~q_mag) : $signed(-q_mag));
    assign o_rem  = (r_neg && rem_nz) ? r_den - r_acc : r_acc;
    assign o_done = r_done;
endmodule

// ----- sv/vrc_dp.sv -----
module vrc_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  vrc_pkg::t_cmd                  i_cmd,
    output vrc_pkg::t_sts                  o_sts,
    input  logic                           i_cfg_valid,
    input  logic [vrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_func,
    input  logic signed [31:0]             i_origin_x,
    input  logic signed [31:0]             i_origin_y,
    input  logic signed [31:0]             i_origin_z,
    input  logic signed [17:0]             i_dir_x,
    input  logic signed [17:0]             i_dir_y,
    input  logic signed [17:0]             i_dir_z,
    input  logic [23:0]                    i_beam_range,
    input  logic                           i_is_hit,
    output logic [8:0]                     o_visited_count,
    output logic signed [17:0]             o_score,
    output logic [1:0]                     o_label
);
    import vrc_pkg::*;

    // configuration
    logic signed [31:0] r_g [3];
    logic [EDGE_W-1:0]  r_edge;
    logic [16:0]        r_thr;

    // latched item
    logic               r_func;
    logic signed [31:0] r_o [3];
    logic signed [17:0] r_d [3];
    logic [23:0]        r_range;
    logic               r_hit;
    logic signed [42:0] r_dr [3];

    // march state
    logic signed [CRD_W-1:0] r_c [3];
    logic signed [CRD_W-1:0] r_t [3];
    logic [EDGE_W-1:0]       r_rem [3];
    logic [DIST_W-1:0]       r_dist [3];
    logic [PROD_W-1:0]       r_pa;
    logic [PROD_W-1:0]       r_pb;
    logic [2:0]              r_le;
    logic [STEP_W-1:0]       r_step;
    logic [STEP_W-1:0]       r_cnt;
    logic [RATIO_W-1:0]      r_ratio;

    // result word
    logic [8:0]         r_vis_o;
    logic signed [17:0] r_score_o;
    t_label             r_label_o;

    logic [EDGE_W-1:0]       edge_eff;
    logic signed [32:0]      rel [3];
    logic [MAG_W-1:0]        mag [3];
    logic signed [NUM_W-1:0] div_num;
    logic [DEN_W-1:0]        div_den;
    logic                    div_done;
    logic signed [Q_W-1:0]   div_q;
    logic [DEN_W-1:0]        div_rem;
    logic [DIST_W-1:0]       da, db;
    logic [MAG_W-1:0]        ma, mb;
    logic                    le_now;
    logic [1:0]              axis;
    logic                    same, c_in, t_in;
    logic [VOX_W-1:0]        idx_c, idx_t;
    logic [COUNT_WIDTH-1:0]  rd_h, rd_ph, rd_pm;
    logic [SUM_W-1:0]        pass_sum, total;
    logic                    sel_h, sel_ph, sel_pm;
    logic [CNTX_W-1:0]       cnt_ext;
    logic signed [NUM_W-1:0] rel_ext;

    function automatic logic in_grid(input logic signed [CRD_W-1:0] x,
                                     input logic signed [CRD_W-1:0] y,
                                     input logic signed [CRD_W-1:0] z);
        in_grid = !x[CRD_W-1] && !y[CRD_W-1] && !z[CRD_W-1] &&
                  x < $signed(CRD_W'(GRID_X)) && y < $signed(CRD_W'(GRID_Y)) &&
                  z < $signed(CRD_W'(GRID_Z));
    endfunction

    function automatic logic [VOX_W-1:0] vidx(input logic signed [CRD_W-1:0] x,
                                              input logic signed [CRD_W-1:0] y,
                                              input logic signed [CRD_W-1:0] z);
        vidx = VOX_W'(x) + VOX_W'(GRID_X) * (VOX_W'(y) + VOX_W'(GRID_Y) * VOX_W'(z));
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
        bump = (v == '1) ? v : v + COUNT_WIDTH'(1);
    endfunction

    assign edge_eff = (r_edge == '0) ? EDGE_W'(1) : r_edge;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            rel[a] = 33'(r_o[a]) - 33'(r_g[a]);
            mag[a] = r_d[a][17] ? MAG_W'(-r_d[a]) : MAG_W'(r_d[a]);
        end
    end

    // divider operands by job
    always_comb begin
        rel_ext = '0;
        div_num = '0;
        div_den = DEN_W'(edge_eff);
        case (i_cmd.job)
            JOB_CX: div_num = NUM_W'(rel[0]);
            JOB_CY: div_num = NUM_W'(rel[1]);
            JOB_CZ: div_num = NUM_W'(rel[2]);
            JOB_TX: begin
                rel_ext = NUM_W'(rel[0]);
                div_num = (rel_ext <<< 16) + NUM_W'(r_dr[0]);
                div_den = DEN_W'({edge_eff, 16'b0});
            end
            JOB_TY: begin
                rel_ext = NUM_W'(rel[1]);
                div_num = (rel_ext <<< 16) + NUM_W'(r_dr[1]);
                div_den = DEN_W'({edge_eff, 16'b0});
            end
            JOB_TZ: begin
                rel_ext = NUM_W'(rel[2]);
                div_num = (rel_ext <<< 16) + NUM_W'(r_dr[2]);
                div_den = DEN_W'({edge_eff, 16'b0});
            end
            JOB_RATIO: begin
                div_num = $signed(NUM_W'({pass_sum, 16'b0}));
                div_den = DEN_W'(total);
            end
            default: div_num = '0;
        endcase
    end

    vrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_q     (div_q),
        .o_rem   (div_rem)
    );

    // operands of the pair under comparison
    always_comb begin
        case (i_cmd.pair)
            PAIR_XY: begin da = r_dist[0]; db = r_dist[1]; ma = mag[0]; mb = mag[1]; end
            PAIR_XZ: begin da = r_dist[0]; db = r_dist[2]; ma = mag[0]; mb = mag[2]; end
            default: begin da = r_dist[1]; db = r_dist[2]; ma = mag[1]; mb = mag[2]; end
        endcase
        if (ma == '0) begin
            le_now = (mb == '0);
        end else if (mb == '0) begin
            le_now = 1'b1;
        end else begin
            le_now = r_pa <= r_pb;
        end
    end

    // ties go to x, then y
    assign axis = (r_le[0] && r_le[1]) ? 2'd0 : (r_le[2] ? 2'd1 : 2'd2);

    assign same  = (r_c[0] == r_t[0]) && (r_c[1] == r_t[1]) && (r_c[2] == r_t[2]);
    assign c_in  = in_grid(r_c[0], r_c[1], r_c[2]);
    assign t_in  = in_grid(r_t[0], r_t[1], r_t[2]);
    assign idx_c = vidx(r_c[0], r_c[1], r_c[2]);
    assign idx_t = vidx(r_t[0], r_t[1], r_t[2]);

    assign pass_sum = SUM_W'(rd_ph) + SUM_W'(rd_pm);
    assign total    = pass_sum + SUM_W'(rd_h);

    assign sel_h  = same && r_hit;
    assign sel_ph = !sel_h && r_hit;
    assign sel_pm = !r_hit;

    vrc_ram #(.W(COUNT_WIDTH), .D(NVOX)) u_ram_hit (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_we || (i_cmd.wr && sel_h)),
        .i_waddr (i_cmd.clr_we ? i_cmd.clr_addr : idx_c),
        .i_wdata (i_cmd.clr_we ? '0 : bump(rd_h)),
        .i_re    (i_cmd.rd),
        .i_raddr (i_cmd.use_t ? idx_t : idx_c),
        .o_rdata (rd_h)
    );

    vrc_ram #(.W(COUNT_WIDTH), .D(NVOX)) u_ram_pass_hit (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_we || (i_cmd.wr && sel_ph)),
        .i_waddr (i_cmd.clr_we ? i_cmd.clr_addr : idx_c),
        .i_wdata (i_cmd.clr_we ? '0 : bump(rd_ph)),
        .i_re    (i_cmd.rd),
        .i_raddr (i_cmd.use_t ? idx_t : idx_c),
        .o_rdata (rd_ph)
    );

    vrc_ram #(.W(COUNT_WIDTH), .D(NVOX)) u_ram_pass_miss (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_we || (i_cmd.wr && sel_pm)),
        .i_waddr (i_cmd.clr_we ? i_cmd.clr_addr : idx_c),
        .i_wdata (i_cmd.clr_we ? '0 : bump(rd_pm)),
        .i_re    (i_cmd.rd),
        .i_raddr (i_cmd.use_t ? idx_t : idx_c),
        .o_rdata (rd_pm)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g[0] <= '0;
            r_g[1] <= '0;
            r_g[2] <= '0;
            r_edge <= EDGE_W'(13107);
            r_thr  <= 17'd32768;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GX:   r_g[0] <= i_cfg_data;
                CFG_GY:   r_g[1] <= i_cfg_data;
                CFG_GZ:   r_g[2] <= i_cfg_data;
                CFG_EDGE: r_edge <= i_cfg_data[EDGE_W-1:0];
                CFG_THR:  r_thr  <= i_cfg_data[16:0];
                default:  ;
            endcase
        end
    end

    assign cnt_ext = CNTX_W'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_func   <= i_func;
            r_o[0]   <= i_origin_x;
            r_o[1]   <= i_origin_y;
            r_o[2]   <= i_origin_z;
            r_d[0]   <= i_dir_x;
            r_d[1]   <= i_dir_y;
            r_d[2]   <= i_dir_z;
            r_range  <= i_beam_range;
            r_hit    <= i_is_hit;
            r_cnt    <= '0;
        end
        if (i_cmd.prep) begin
            for (int a = 0; a < 3; a++) begin
                r_dr[a] <= r_d[a] * $signed({1'b0, r_range});
            end
        end
        if (i_cmd.div_store && div_done) begin
            case (i_cmd.job)
                JOB_CX: begin r_c[0] <= CRD_W'(div_q); r_rem[0] <= EDGE_W'(div_rem); end
                JOB_CY: begin r_c[1] <= CRD_W'(div_q); r_rem[1] <= EDGE_W'(div_rem); end
                JOB_CZ: begin r_c[2] <= CRD_W'(div_q); r_rem[2] <= EDGE_W'(div_rem); end
                JOB_TX: r_t[0] <= CRD_W'(div_q);
                JOB_TY: r_t[1] <= CRD_W'(div_q);
                JOB_TZ: r_t[2] <= CRD_W'(div_q);
                default: r_ratio <= RATIO_W'(div_q);
            endcase
        end
        if (i_cmd.init_march) begin
            for (int a = 0; a < 3; a++) begin
                if (r_d[a][17]) begin
                    r_dist[a] <= DIST_W'(r_rem[a]);
                end else if (r_d[a] != '0) begin
                    r_dist[a] <= DIST_W'(edge_eff - r_rem[a]);
                end else begin
                    r_dist[a] <= '0;
                end
            end
            r_step <= '0;
        end
        if (i_cmd.mul) begin
            r_pa <= PROD_W'(da * mb);
            r_pb <= PROD_W'(db * ma);
        end
        if (i_cmd.cmp) begin
            case (i_cmd.pair)
                PAIR_XY: r_le[0] <= le_now;
                PAIR_XZ: r_le[1] <= le_now;
                default: r_le[2] <= le_now;
            endcase
        end
        if (i_cmd.advance) begin
            for (int a = 0; a < 3; a++) begin
                if (axis == 2'(a)) begin
                    if (r_d[a][17]) begin
                        r_c[a] <= r_c[a] - CRD_W'(1);
                    end else if (r_d[a] != '0) begin
                        r_c[a] <= r_c[a] + CRD_W'(1);
                    end
                    r_dist[a] <= r_dist[a] + DIST_W'(edge_eff);
                end
            end
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.wr && i_cmd.count_inc) begin
            r_cnt <= r_cnt + STEP_W'(1);
        end
        if (i_cmd.out_load) begin
            case (i_cmd.okind)
                OK_CARVE: begin
                    r_vis_o   <= (cnt_ext > CNTX_W'(511)) ? 9'd511 : cnt_ext[8:0];
                    r_score_o <= NO_SCORE;
                    r_label_o <= LBL_NONE;
                end
                OK_NOSCORE: begin
                    r_vis_o   <= '0;
                    r_score_o <= NO_SCORE;
                    r_label_o <= LBL_NONE;
                end
                OK_ZERO: begin
                    r_vis_o   <= '0;
                    r_score_o <= '0;
                    r_label_o <= (r_thr == '0) ? LBL_DYNAMIC : LBL_STATIC;
                end
                default: begin
                    r_vis_o   <= '0;
                    r_score_o <= $signed({1'b0, r_ratio});
                    r_label_o <= (r_ratio >= r_thr) ? LBL_DYNAMIC : LBL_STATIC;
                end
            endcase
        end
    end

    always_comb begin
        o_sts.div_done   = div_done;
        o_sts.func       = r_func;
        o_sts.hit        = r_hit;
        o_sts.same       = same;
        o_sts.c_in       = c_in;
        o_sts.t_in       = t_in;
        o_sts.total_zero = (total == '0);
        o_sts.step_last  = (r_step == STEP_W'(MAX_STEPS));
    end

    assign o_visited_count = r_vis_o;
    assign o_score         = r_score_o;
    assign o_label         = r_label_o;
endmodule

// ----- sv/vrc_ctrl.sv -----
module vrc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  vrc_pkg::t_sts i_sts,
    output vrc_pkg::t_cmd o_cmd
);
    import vrc_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PREP, S_DIVGO, S_DIVW, S_DECIDE, S_INIT, S_MUL,
        S_CMP, S_ADV, S_CHK, S_RD, S_WR, S_CLS, S_FIN
    } t_state;

    typedef enum logic [1:0] {
        MODE_SAME, MODE_MARCH, MODE_CLS
    } t_mode;

    t_state           r_state, n_state;
    logic [VOX_W-1:0] r_clr, n_clr;
    t_job             r_job, n_job;
    t_pair            r_pair, n_pair;
    t_mode            r_mode, n_mode;
    t_okind           r_okind, n_okind;
    logic             r_ovalid, n_ovalid;

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_job    = r_job;
        n_pair   = r_pair;
        n_mode   = r_mode;
        n_okind  = r_okind;
        o_cmd    = '0;
        o_cmd.job  = r_job;
        o_cmd.pair = r_pair;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we   = 1'b1;
                o_cmd.clr_addr = r_clr;
                n_clr          = r_clr + VOX_W'(1);
                if (r_clr == VOX_W'(NVOX - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_job      = JOB_CX;
                n_state    = S_DIVGO;
            end
            S_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVW;
            end
            S_DIVW: begin
                o_cmd.div_store = 1'b1;
                if (i_sts.div_done) begin
                    if (r_job == JOB_TZ) begin
                        n_state = S_DECIDE;
                    end else if (r_job == JOB_RATIO) begin
                        n_okind = OK_RATIO;
                        n_state = S_FIN;
                    end else begin
                        n_job   = t_job'(r_job + 3'd1);
                        n_state = S_DIVGO;
                    end
                end
            end
            S_DECIDE: begin
                if (i_sts.func) begin
                    if (i_sts.hit && i_sts.t_in) begin
                        n_mode  = MODE_CLS;
                        n_state = S_RD;
                    end else begin
                        n_okind = OK_NOSCORE;
                        n_state = S_FIN;
                    end
                end else if (i_sts.same) begin
                    if (i_sts.hit && i_sts.c_in) begin
                        n_mode  = MODE_SAME;
                        n_state = S_RD;
                    end else begin
                        n_okind = OK_CARVE;
                        n_state = S_FIN;
                    end
                end else begin
                    n_mode  = MODE_MARCH;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init_march = 1'b1;
                n_pair           = PAIR_XY;
                n_state          = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (r_pair == PAIR_YZ) begin
                    n_state = S_ADV;
                end else begin
                    n_pair  = t_pair'(r_pair + 2'd1);
                    n_state = S_MUL;
                end
            end
            S_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = S_CHK;
            end
            S_CHK: begin
                if (!i_sts.c_in) begin
                    n_okind = OK_CARVE;
                    n_state = S_FIN;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd    = 1'b1;
                o_cmd.use_t = (r_mode == MODE_CLS);
                n_state     = (r_mode == MODE_CLS) ? S_CLS : S_WR;
            end
            S_WR: begin
                o_cmd.wr        = 1'b1;
                o_cmd.count_inc = (r_mode == MODE_MARCH);
                if (i_sts.same || i_sts.step_last) begin
                    n_okind = OK_CARVE;
                    n_state = S_FIN;
                end else begin
                    n_pair  = PAIR_XY;
                    n_state = S_MUL;
                end
            end
            S_CLS: begin
                if (i_sts.total_zero) begin
                    n_okind = OK_ZERO;
                    n_state = S_FIN;
                end else begin
                    n_job   = JOB_RATIO;
                    n_state = S_DIVGO;
                end
            end
            S_FIN: begin
                o_cmd.okind = r_okind;
                if (!r_ovalid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_ovalid = r_ovalid;
        if (o_cmd.out_load) begin
            n_ovalid = 1'b1;
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_job    <= JOB_CX;
            r_pair   <= PAIR_XY;
            r_mode   <= MODE_SAME;
            r_okind  <= OK_CARVE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_job    <= n_job;
            r_pair   <= n_pair;
            r_mode   <= n_mode;
            r_okind  <= n_okind;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
endmodule

// ----- sv/voxel_ray_carve_classify.sv -----
// lidar free-space carving over a voxel grid of saturating hit, pass-from-hit
// and pass-from-miss counters, with endpoint classification; all positions are
// q16.16 meters. after reset the block clears its three counter memories, one
// voxel a cycle, all GRID_X*GRID_Y*GRID_Z voxels (65536 with the package sizes),
// and takes no word in that time; configuration writes are taken at any time
// but are meant to be issued while the block is idle. every item runs through
// a shared bit-serial divider that finds the start and end voxel on each axis:
// six divisions in all. a carve word then marches voxel by voxel, each voxel
// taking three cross multiplied tmax compares, each a multiply and a compare,
// the step, the grid check, and a read-modify-write of the counter memory, up
// to MAX_STEPS voxels. a classify word for a hit inside the grid reads the end
// voxel's counters and, unless they are all zero, runs one more division for
// the pass ratio. a finished result sits in the output register while the
// next word is taken.
module voxel_ray_carve_classify (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic signed [31:0]            i_origin_x,
    input  logic signed [31:0]            i_origin_y,
    input  logic signed [31:0]            i_origin_z,
    input  logic signed [17:0]            i_dir_x,
    input  logic signed [17:0]            i_dir_y,
    input  logic signed [17:0]            i_dir_z,
    input  logic [23:0]                   i_beam_range,
    input  logic                          i_is_hit,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [8:0]                    o_visited_count,
    output logic signed [17:0]            o_score,
    output logic [1:0]                    o_label,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [vrc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import vrc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // register writes are always taken and land in the next cycle
    assign o_cfg_ready = 1'b1;

    // sequencer: clearing pass, division jobs, march steps, result hand-off
    vrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // geometry, divider, counter memories and result register
    vrc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_func),
        .i_origin_x      (i_origin_x),
        .i_origin_y      (i_origin_y),
        .i_origin_z      (i_origin_z),
        .i_dir_x         (i_dir_x),
        .i_dir_y         (i_dir_y),
        .i_dir_z         (i_dir_z),
        .i_beam_range    (i_beam_range),
        .i_is_hit        (i_is_hit),
        .o_visited_count (o_visited_count),
        .o_score         (o_score),
        .o_label         (o_label)
    );
endmodule

// ----- sv/vrc_check.sv -----
module vrc_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [8:0]         o_visited_count,
    input logic signed [17:0] o_score,
    input logic [1:0]         o_label
);
    import vrc_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_score) && $stable(o_label) &&
        $stable(o_visited_count))
        else $error("stalled result changed");

    a_unlabeled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_label == LBL_NONE |-> o_score == NO_SCORE)
        else $error("unlabeled result carries a score");

    a_labeled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_label != LBL_NONE |-> o_visited_count == 9'd0 && !o_score[17] &&
        o_score <= 18'sd65536 && (o_label == LBL_STATIC || o_label == LBL_DYNAMIC))
        else $error("classify result out of range");
endmodule

bind voxel_ray_carve_classify vrc_check u_check (.*);
